FILE: hw/rtl/dmrs_pkg.sv
// Shared types, constants and phase table for the uplink DMRS shift and mapper.
`timescale 1ns / 1ps

package dmrs_pkg;

    localparam int FFT_W      = 13;
    localparam int OFF_W      = 12;
    localparam int RB_W       = 7;
    localparam int ADDR_W     = 20;
    localparam int SHIFT_W    = 4;
    localparam int SAMP_W     = 16;
    localparam int CNT_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_FFT_SIZE_DEF = 4096;
    localparam int MAX_RB_DEF       = 110;

    localparam logic [SHIFT_W-1:0] NUM_PHASES = 4'd12;
    localparam logic [OFF_W-1:0]   RB_CARRIERS = 12'd12;
    localparam logic [OFF_W-1:0]   DC_ODD_LAND = 12'd6;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_AMP        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SHIFT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_OFF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FFT_SIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DC_ODD     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_RB   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NB_RB      = 3'd6;

    localparam logic signed [SAMP_W-1:0] AMP_RST      = 16'sd32767;
    localparam logic [FFT_W-1:0]         FFT_SIZE_RST = 13'd512;
    localparam logic [RB_W-1:0]          NB_RB_RST    = 7'd1;

    // Item kinds
    localparam logic KIND_SYMBOL = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic [ADDR_W-1:0]         symbol_base;
        logic [SHIFT_W-1:0]        hop_shift;
        logic signed [SAMP_W-1:0]  ref_re;
        logic signed [SAMP_W-1:0]  ref_im;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]         grid_address;
        logic signed [SAMP_W-1:0]  out_re;
        logic signed [SAMP_W-1:0]  out_im;
    } result_t;

    typedef struct packed {
        logic load_symbol;
        logic skip_step;
        logic load_sample;
        logic rotate;
        logic scale;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic kind;
        logic in_budget;
        logic skip_pending;
        logic out_free;
    } dp_status_t;

    // Q15 cosine of the twelve phase steps
    function automatic logic signed [SAMP_W-1:0] rot_cos(input logic [SHIFT_W-1:0] idx);
        logic signed [SAMP_W-1:0] v;
        case (idx)
            4'd0:    v = 16'sd32767;
            4'd1:    v = 16'sd28377;
            4'd2:    v = 16'sd16383;
            4'd3:    v = 16'sd0;
            4'd4:    v = -16'sd16384;
            4'd5:    v = -16'sd28378;
            4'd6:    v = -16'sd32768;
            4'd7:    v = -16'sd28378;
            4'd8:    v = -16'sd16384;
            4'd9:    v = -16'sd1;
            4'd10:   v = 16'sd16383;
            4'd11:   v = 16'sd28377;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    // Q15 sine of the twelve phase steps
    function automatic logic signed [SAMP_W-1:0] rot_sin(input logic [SHIFT_W-1:0] idx);
        logic signed [SAMP_W-1:0] v;
        case (idx)
            4'd0:    v = 16'sd0;
            4'd1:    v = 16'sd16383;
            4'd2:    v = 16'sd28377;
            4'd3:    v = 16'sd32767;
            4'd4:    v = 16'sd28377;
            4'd5:    v = 16'sd16383;
            4'd6:    v = 16'sd0;
            4'd7:    v = -16'sd16384;
            4'd8:    v = -16'sd28378;
            4'd9:    v = -16'sd32768;
            4'd10:   v = -16'sd28378;
            4'd11:   v = -16'sd16384;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/uplink_dmrs_shift_and_map_top.sv
// Top level of the uplink DMRS cyclic shift and subcarrier mapper.
`timescale 1ns / 1ps

// Maps uplink demodulation reference samples onto grid addresses. A beat with
// kind 0 opens a symbol: it latches the symbol base, forms the cyclic shift as
// (base_shift + hop_shift) mod 12, restarts the phase and walks the start
// offset over the leading resource blocks (the start RB register, index 5) of
// 12 subcarriers, one block per clock, so it holds the input until the walk is
// done. A beat with kind 1 is a sample: it is rotated by the current phase
// step, scaled by amp and leaves as one result beat with its grid address. A
// sample goes from its input beat to the output register through the multiply
// by the phase table, the sum, the multiply by amp and the load; the input is
// taken again once the result has reached the output register, so a sample
// beat can arrive while the previous result still waits downstream. If that
// result is still waiting when the next sample reaches the load stage, hold
// the sample there until the output register frees. Samples beyond the
// symbol's budget of 12 per resource block are taken and dropped.
// Configuration writes are registered directly and are to be made between
// items only.

module uplink_dmrs_shift_and_map_top #(
    parameter int MAX_FFT_SIZE = dmrs_pkg::MAX_FFT_SIZE_DEF,
    parameter int MAX_RB       = dmrs_pkg::MAX_RB_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration writes
    input  logic                             cfg_we,
    input  logic [dmrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dmrs_pkg::CFG_DATA_W-1:0]  cfg_data,
    // symbol-start and sample beats
    input  logic                             item_valid,
    output logic                             item_ready,
    input  dmrs_pkg::item_t                  item,
    // mapped sample beats
    output logic                             result_valid,
    input  logic                             result_ready,
    output dmrs_pkg::result_t                result
);

    dmrs_pkg::dp_cmd_t    cmd;
    dmrs_pkg::dp_status_t status;

    // Sequence the symbol walk and the sample pipeline
    dmrs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Hold configuration and symbol state, rotate, scale and drive the result
    dmrs_dp #(
        .MAX_FFT_SIZE (MAX_FFT_SIZE),
        .MAX_RB       (MAX_RB)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

FILE: hw/rtl/dmrs_ctrl.sv
// Control state machine sequencing symbol set-up and sample processing.
`timescale 1ns / 1ps

module dmrs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  dmrs_pkg::dp_status_t  status,
    output dmrs_pkg::dp_cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SKIP  = 3'd1;
    localparam logic [2:0] ST_ROT   = 3'd2;
    localparam logic [2:0] ST_SCALE = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        item_ready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (status.kind == dmrs_pkg::KIND_SYMBOL)
                    begin
                        cmd.load_symbol = 1'b1;
                        state_next      = ST_SKIP;
                    end
                    else if (status.in_budget)
                    begin
                        cmd.load_sample = 1'b1;
                        state_next      = ST_ROT;
                    end
                    // over budget: take the beat and drop it
                end
            end
            ST_SKIP:
            begin
                if (status.skip_pending)
                begin
                    cmd.skip_step = 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ROT:
            begin
                cmd.rotate = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/dmrs_dp.sv
// Datapath: configuration, symbol state, offset skipping, rotation, scaling, output register.
`timescale 1ns / 1ps

module dmrs_dp #(
    parameter int MAX_FFT_SIZE = dmrs_pkg::MAX_FFT_SIZE_DEF,
    parameter int MAX_RB       = dmrs_pkg::MAX_RB_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [dmrs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dmrs_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  dmrs_pkg::item_t                       item,
    input  dmrs_pkg::dp_cmd_t                     cmd,
    output dmrs_pkg::dp_status_t                  status,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output dmrs_pkg::result_t                     result
);

    localparam int FFT_W   = dmrs_pkg::FFT_W;
    localparam int OFF_W   = dmrs_pkg::OFF_W;
    localparam int RB_W    = dmrs_pkg::RB_W;
    localparam int ADDR_W  = dmrs_pkg::ADDR_W;
    localparam int SHIFT_W = dmrs_pkg::SHIFT_W;
    localparam int SAMP_W  = dmrs_pkg::SAMP_W;
    localparam int CNT_W   = dmrs_pkg::CNT_W;
    localparam int PROD_W  = 2 * SAMP_W;

    localparam logic [FFT_W-1:0] MAX_FFT_C = FFT_W'(MAX_FFT_SIZE);
    localparam logic [RB_W-1:0]  MAX_RB_C  = RB_W'(MAX_RB);

    // Configuration registers
    logic signed [SAMP_W-1:0] amp_reg;
    logic [SHIFT_W-1:0]       base_shift_reg;
    logic [OFF_W-1:0]         first_off_reg;
    logic [FFT_W-1:0]         fft_size_reg;
    logic                     dc_odd_reg;
    logic [RB_W-1:0]          start_rb_reg;
    logic [RB_W-1:0]          nb_rb_reg;

    // Symbol state
    logic [SHIFT_W-1:0] phase_index_reg;
    logic [OFF_W-1:0]   carrier_offset_reg;
    logic [CNT_W-1:0]   sample_count_reg;
    logic [SHIFT_W-1:0] active_shift_reg;
    logic [ADDR_W-1:0]  active_base_reg;
    logic [RB_W-1:0]    skip_cnt_reg;

    // Sample pipeline
    logic [ADDR_W-1:0]        addr_reg;
    logic signed [PROD_W-1:0] prod_rc_reg;
    logic signed [PROD_W-1:0] prod_is_reg;
    logic signed [PROD_W-1:0] prod_rs_reg;
    logic signed [PROD_W-1:0] prod_ic_reg;
    logic signed [SAMP_W-1:0] rot_re_reg;
    logic signed [SAMP_W-1:0] rot_im_reg;
    logic signed [PROD_W-1:0] scl_re_reg;
    logic signed [PROD_W-1:0] scl_im_reg;
    logic                     result_valid_reg;
    dmrs_pkg::result_t        result_reg;

    logic [FFT_W-1:0]         wrap_point;
    logic [SHIFT_W:0]         shift_sum;
    logic [SHIFT_W-1:0]       shift_mod;
    logic [FFT_W-1:0]         skip_sum;
    logic [OFF_W-1:0]         skip_off_next;
    logic [FFT_W-1:0]         inc_sum;
    logic [OFF_W-1:0]         carrier_offset_next;
    logic [SHIFT_W:0]         phase_sum;
    logic [SHIFT_W-1:0]       phase_index_next;
    logic [RB_W-1:0]          rb_room;
    logic [RB_W-1:0]          rb_count;
    logic [CNT_W-1:0]         sample_limit;
    logic signed [SAMP_W-1:0] cos_val;
    logic signed [SAMP_W-1:0] sin_val;
    logic signed [SAMP_W-1:0] ref_re_s;
    logic signed [SAMP_W-1:0] ref_im_s;
    logic signed [PROD_W:0]   rot_re_sum;
    logic signed [PROD_W:0]   rot_im_sum;

    assign wrap_point = (fft_size_reg < MAX_FFT_C) ? fft_size_reg : MAX_FFT_C;

    // Cyclic shift, reduced mod 12 from a sum of at most 30
    always_comb
    begin
        shift_sum = {1'b0, base_shift_reg} + {1'b0, item.hop_shift};
        if (shift_sum >= 5'd24)
        begin
            shift_mod = SHIFT_W'(shift_sum - 5'd24);
        end
        else if (shift_sum >= 5'd12)
        begin
            shift_mod = SHIFT_W'(shift_sum - 5'd12);
        end
        else
        begin
            shift_mod = SHIFT_W'(shift_sum);
        end
    end

    // One resource block skip per step
    assign skip_sum      = {1'b0, carrier_offset_reg} + {1'b0, dmrs_pkg::RB_CARRIERS};
    assign skip_off_next = (skip_sum >= wrap_point)
                         ? (dc_odd_reg ? dmrs_pkg::DC_ODD_LAND : '0)
                         : skip_sum[OFF_W-1:0];

    assign inc_sum             = {1'b0, carrier_offset_reg} + FFT_W'(1);
    assign carrier_offset_next = (inc_sum >= wrap_point) ? '0 : inc_sum[OFF_W-1:0];

    assign phase_sum        = {1'b0, phase_index_reg} + {1'b0, active_shift_reg};
    assign phase_index_next = (phase_sum >= {1'b0, dmrs_pkg::NUM_PHASES})
                            ? SHIFT_W'(phase_sum - {1'b0, dmrs_pkg::NUM_PHASES})
                            : phase_sum[SHIFT_W-1:0];

    // Sample budget: 12 per usable resource block
    assign rb_room      = MAX_RB_C - start_rb_reg;
    assign rb_count     = (start_rb_reg < MAX_RB_C)
                        ? ((nb_rb_reg < rb_room) ? nb_rb_reg : rb_room)
                        : '0;
    assign sample_limit = (CNT_W'(rb_count) << 3) + (CNT_W'(rb_count) << 2);

    assign cos_val  = dmrs_pkg::rot_cos(phase_index_reg);
    assign sin_val  = dmrs_pkg::rot_sin(phase_index_reg);
    assign ref_re_s = item.ref_re;
    assign ref_im_s = item.ref_im;

    assign rot_re_sum = {prod_rc_reg[PROD_W-1], prod_rc_reg} - {prod_is_reg[PROD_W-1], prod_is_reg};
    assign rot_im_sum = {prod_rs_reg[PROD_W-1], prod_rs_reg} + {prod_ic_reg[PROD_W-1], prod_ic_reg};

    assign status.kind         = item.kind;
    assign status.in_budget    = (sample_count_reg < sample_limit);
    assign status.skip_pending = (skip_cnt_reg != '0);
    assign status.out_free     = !result_valid_reg || result_ready;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg        <= dmrs_pkg::AMP_RST;
            base_shift_reg <= '0;
            first_off_reg  <= '0;
            fft_size_reg   <= dmrs_pkg::FFT_SIZE_RST;
            dc_odd_reg     <= 1'b0;
            start_rb_reg   <= '0;
            nb_rb_reg      <= dmrs_pkg::NB_RB_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dmrs_pkg::REG_AMP:        amp_reg        <= SAMP_W'(cfg_data);
                dmrs_pkg::REG_BASE_SHIFT: base_shift_reg <= cfg_data[SHIFT_W-1:0];
                dmrs_pkg::REG_FIRST_OFF:  first_off_reg  <= cfg_data[OFF_W-1:0];
                dmrs_pkg::REG_FFT_SIZE:   fft_size_reg   <= cfg_data[FFT_W-1:0];
                dmrs_pkg::REG_DC_ODD:     dc_odd_reg     <= cfg_data[0];
                dmrs_pkg::REG_START_RB:   start_rb_reg   <= cfg_data[RB_W-1:0];
                dmrs_pkg::REG_NB_RB:      nb_rb_reg      <= cfg_data[RB_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_index_reg    <= '0;
            carrier_offset_reg <= '0;
            sample_count_reg   <= '0;
            active_shift_reg   <= '0;
            active_base_reg    <= '0;
            skip_cnt_reg       <= '0;
        end
        else if (cmd.load_symbol)
        begin
            phase_index_reg    <= '0;
            carrier_offset_reg <= first_off_reg;
            sample_count_reg   <= '0;
            active_shift_reg   <= shift_mod;
            active_base_reg    <= item.symbol_base;
            skip_cnt_reg       <= start_rb_reg;
        end
        else if (cmd.skip_step)
        begin
            carrier_offset_reg <= skip_off_next;
            skip_cnt_reg       <= skip_cnt_reg - RB_W'(1);
        end
        else if (cmd.load_sample)
        begin
            phase_index_reg    <= phase_index_next;
            carrier_offset_reg <= carrier_offset_next;
            sample_count_reg   <= sample_count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            addr_reg    <= active_base_reg + ADDR_W'(carrier_offset_reg);
            prod_rc_reg <= ref_re_s * cos_val;
            prod_is_reg <= ref_im_s * sin_val;
            prod_rs_reg <= ref_re_s * sin_val;
            prod_ic_reg <= ref_im_s * cos_val;
        end
        if (cmd.rotate)
        begin
            // floor shift by 15, wrap to 16 bits
            rot_re_reg <= rot_re_sum[SAMP_W+14:15];
            rot_im_reg <= rot_im_sum[SAMP_W+14:15];
        end
        if (cmd.scale)
        begin
            scl_re_reg <= rot_re_reg * amp_reg;
            scl_im_reg <= rot_im_reg * amp_reg;
        end
        if (cmd.emit)
        begin
            result_reg.grid_address <= addr_reg;
            result_reg.out_re       <= scl_re_reg[SAMP_W+14:15];
            result_reg.out_im       <= scl_im_reg[SAMP_W+14:15];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

endmodule

FILE: hw/rtl/dmrs_checker.sv
// Port-level checks for the uplink DMRS mapper, bound to the top level.
`timescale 1ns / 1ps

module dmrs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input dmrs_pkg::item_t    item,
    input logic               result_valid,
    input logic               result_ready,
    input dmrs_pkg::result_t  result
);

    // A waiting result beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // Valid drops only after a taken beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(result_valid) |-> $past(result_ready))
        else $error("result beat dropped without ready");

    // A fresh result follows an accepted sample beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |->
            $past(item_valid && item_ready && item.kind == dmrs_pkg::KIND_SAMPLE, 4))
        else $error("result appeared without a matching sample beat");

    // A symbol start holds the input while the offset walk runs
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.kind == dmrs_pkg::KIND_SYMBOL |=> !item_ready)
        else $error("input taken during symbol set-up");

endmodule

bind uplink_dmrs_shift_and_map_top dmrs_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
